// ===== sv/aligned_bump_arena_allocator_macros.svh =====
// Assertion macros shared by the arena allocator RTL.
`ifndef ALIGNED_BUMP_ARENA_ALLOCATOR_MACROS_SVH
`define ALIGNED_BUMP_ARENA_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define ABA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aligned_bump_arena_allocator: assertion failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define ABA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aligned_bump_arena_allocator: assertion failed");

`endif

// ===== sv/aba_pkg.sv =====
// Types and constants shared by the arena allocator modules.
`timescale 1ns / 1ps

package aba_pkg;

   localparam int KIND_W  = 3;
   localparam int REQ_W   = 24;
   localparam int OFF_W   = 24;
   localparam int CNT_W   = 32;
   localparam int BYTE_W  = 40;
   localparam int CAP_W   = 24;
   localparam int MIS_W   = 4;
   localparam int CSR_W   = 24;

   // Every allocation is preceded by a size header of one 64-bit word.
   localparam int unsigned HDR_BYTES = 8;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 24'd65536;
   localparam logic [MIS_W-1:0] MISALIGN_RESET = 4'd0;

   typedef enum logic {
      CSR_ARENA_CAPACITY = 1'b0,
      CSR_BASE_MISALIGN  = 1'b1
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC       = 3'd0,
      KIND_ARENA_RESET = 3'd1,
      KIND_CKPT_SAVE   = 3'd2,
      KIND_CKPT_RESTORE = 3'd3,
      KIND_STATS_CLEAR = 3'd4,
      KIND_INIT        = 3'd5
   } kind_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [REQ_W-1:0]  request_bytes;
      logic [REQ_W-1:0]  restore_offset;
   } req_item_type;

   typedef struct packed {
      logic [OFF_W-1:0]  payload_offset;
      logic              overflow;
      logic [OFF_W-1:0]  current_offset;
      logic              overflow_seen;
      logic [CNT_W-1:0]  alloc_count;
      logic [BYTE_W-1:0] alloc_bytes;
      logic [OFF_W-1:0]  high_water;
      logic [CNT_W-1:0]  reset_count;
      logic [CNT_W-1:0]  restore_count;
      logic [CNT_W-1:0]  overflow_count;
      logic [BYTE_W-1:0] spilled_bytes;
   } rsp_type;

endpackage

// ===== sv/aba_in_stage.sv =====
// Input register of the arena allocator with its stall logic.
`timescale 1ns / 1ps

module aba_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  aba_pkg::req_item_type req_item,
   input  logic                 advance,
   output logic                 item_valid,
   output aba_pkg::req_item_type item
);

   logic                  valid_ff;
   logic                  valid_in;
   aba_pkg::req_item_type item_ff;
   logic                  load;

   // The held item leaves in the cycle it advances, so a new one may enter then.
   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== sv/aba_engine.sv =====
// Arena state registers and the combinational command logic that updates them.
`timescale 1ns / 1ps

module aba_engine #(
   parameter int ALIGN_BYTES = 16,
   parameter int ADDR_BITS   = 24,
   parameter int COUNT_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  aba_pkg::req_item_type         item,
   input  logic [aba_pkg::CAP_W-1:0]     arena_capacity,
   input  logic [aba_pkg::MIS_W-1:0]     base_misalign,
   output aba_pkg::rsp_type              result
);

   // Wide enough that offset, header, padding and request never wrap.
   localparam int EXT_BITS =
      ((ADDR_BITS > aba_pkg::REQ_W) ? ADDR_BITS : aba_pkg::REQ_W) + 2;
   localparam logic [EXT_BITS-1:0] PAD_MASK = EXT_BITS'(ALIGN_BYTES - 1);

   logic [ADDR_BITS-1:0]        offset_ff, offset_in;
   logic                        ovf_flag_ff, ovf_flag_in;
   logic [COUNT_BITS-1:0]       alloc_cnt_ff, alloc_cnt_in;
   logic [aba_pkg::BYTE_W-1:0]  byte_cnt_ff, byte_cnt_in;
   logic [ADDR_BITS-1:0]        water_ff, water_in;
   logic [COUNT_BITS-1:0]       reset_cnt_ff, reset_cnt_in;
   logic [COUNT_BITS-1:0]       restore_cnt_ff, restore_cnt_in;
   logic [COUNT_BITS-1:0]       ovf_cnt_ff, ovf_cnt_in;
   logic [aba_pkg::BYTE_W-1:0]  ovf_byte_ff, ovf_byte_in;

   logic [EXT_BITS-1:0] hdr_off;
   logic [EXT_BITS-1:0] pad;
   logic [EXT_BITS-1:0] payload;
   logic [EXT_BITS-1:0] end_off;
   logic [EXT_BITS-1:0] init_pad;
   logic                fits;
   logic [EXT_BITS-1:0] payload_out;
   logic                ovf_out;

   // Alignment is a power of two, so padding is the negated sum under the mask.
   assign hdr_off  = EXT_BITS'(offset_ff) + EXT_BITS'(aba_pkg::HDR_BYTES);
   assign pad      = (EXT_BITS'(0) - (EXT_BITS'(base_misalign) + hdr_off)) & PAD_MASK;
   assign payload  = hdr_off + pad;
   assign end_off  = payload + EXT_BITS'(item.request_bytes);
   assign init_pad = (EXT_BITS'(0) - EXT_BITS'(base_misalign)) & PAD_MASK;
   assign fits     = end_off < EXT_BITS'(arena_capacity);

   always_comb begin
      offset_in      = offset_ff;
      ovf_flag_in    = ovf_flag_ff;
      alloc_cnt_in   = alloc_cnt_ff;
      byte_cnt_in    = byte_cnt_ff;
      water_in       = water_ff;
      reset_cnt_in   = reset_cnt_ff;
      restore_cnt_in = restore_cnt_ff;
      ovf_cnt_in     = ovf_cnt_ff;
      ovf_byte_in    = ovf_byte_ff;
      payload_out    = '0;
      ovf_out        = 1'b0;
      case (aba_pkg::kind_type'(item.kind))
         aba_pkg::KIND_ALLOC: begin
            if (fits) begin
               offset_in    = ADDR_BITS'(end_off);
               alloc_cnt_in = alloc_cnt_ff + COUNT_BITS'(1);
               byte_cnt_in  = byte_cnt_ff + aba_pkg::BYTE_W'(item.request_bytes);
               if (end_off > EXT_BITS'(water_ff)) begin
                  water_in = ADDR_BITS'(end_off);
               end
               payload_out = payload;
            end else begin
               ovf_cnt_in  = ovf_cnt_ff + COUNT_BITS'(1);
               ovf_byte_in = ovf_byte_ff + aba_pkg::BYTE_W'(item.request_bytes);
               ovf_flag_in = 1'b1;
               ovf_out     = 1'b1;
            end
         end
         aba_pkg::KIND_ARENA_RESET: begin
            offset_in    = '0;
            ovf_flag_in  = 1'b0;
            reset_cnt_in = reset_cnt_ff + COUNT_BITS'(1);
         end
         aba_pkg::KIND_CKPT_SAVE: begin
            offset_in = offset_ff;
         end
         aba_pkg::KIND_CKPT_RESTORE: begin
            offset_in      = ADDR_BITS'(item.restore_offset);
            restore_cnt_in = restore_cnt_ff + COUNT_BITS'(1);
         end
         aba_pkg::KIND_STATS_CLEAR: begin
            alloc_cnt_in   = '0;
            byte_cnt_in    = '0;
            reset_cnt_in   = '0;
            restore_cnt_in = '0;
            ovf_cnt_in     = '0;
            ovf_byte_in    = '0;
         end
         aba_pkg::KIND_INIT: begin
            offset_in      = ADDR_BITS'(init_pad);
            ovf_flag_in    = 1'b0;
            water_in       = '0;
            alloc_cnt_in   = '0;
            byte_cnt_in    = '0;
            reset_cnt_in   = '0;
            restore_cnt_in = '0;
            ovf_cnt_in     = '0;
            ovf_byte_in    = '0;
         end
         default: begin
            // Unused command codes leave the state untouched.
            offset_in = offset_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff      <= '0;
         ovf_flag_ff    <= 1'b0;
         alloc_cnt_ff   <= '0;
         byte_cnt_ff    <= '0;
         water_ff       <= '0;
         reset_cnt_ff   <= '0;
         restore_cnt_ff <= '0;
         ovf_cnt_ff     <= '0;
         ovf_byte_ff    <= '0;
      end else if (advance) begin
         offset_ff      <= offset_in;
         ovf_flag_ff    <= ovf_flag_in;
         alloc_cnt_ff   <= alloc_cnt_in;
         byte_cnt_ff    <= byte_cnt_in;
         water_ff       <= water_in;
         reset_cnt_ff   <= reset_cnt_in;
         restore_cnt_ff <= restore_cnt_in;
         ovf_cnt_ff     <= ovf_cnt_in;
         ovf_byte_ff    <= ovf_byte_in;
      end
   end

   always_comb begin
      result.payload_offset = aba_pkg::OFF_W'(payload_out);
      result.overflow       = ovf_out;
      result.current_offset = aba_pkg::OFF_W'(offset_in);
      result.overflow_seen  = ovf_flag_in;
      result.alloc_count    = aba_pkg::CNT_W'(alloc_cnt_in);
      result.alloc_bytes    = byte_cnt_in;
      result.high_water     = aba_pkg::OFF_W'(water_in);
      result.reset_count    = aba_pkg::CNT_W'(reset_cnt_in);
      result.restore_count  = aba_pkg::CNT_W'(restore_cnt_in);
      result.overflow_count = aba_pkg::CNT_W'(ovf_cnt_in);
      result.spilled_bytes  = ovf_byte_in;
   end

endmodule

// ===== sv/aligned_bump_arena_allocator.sv =====
// Top level of the bump-pointer arena allocator with its result register.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  kind, request_bytes, restore_offset
//   rsp_      out        rsp_valid/rsp_stall  one result item per command
//   csr_      in         csr_write_en         csr_index, csr_write_data
//
// One item per cycle sustained while rsp_stall stays low; each item is held in the
// input register, and its result is captured in the result register as it advances.
// The arena state is updated by the combinational command logic, so each item
// sees the state that the previous one left. Reset restores capacity 65536 and
// zero misalignment and clears all state at once. A stalled result blocks the
// input register; one more item is still taken while a result waits.
`timescale 1ns / 1ps

`include "aligned_bump_arena_allocator_macros.svh"

module aligned_bump_arena_allocator #(
   parameter int ALIGN_BYTES = 16,
   parameter int ADDR_BITS   = 24,
   parameter int COUNT_BITS  = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [aba_pkg::KIND_W-1:0]     req_kind,
   input  logic [aba_pkg::REQ_W-1:0]      req_request_bytes,
   input  logic [aba_pkg::REQ_W-1:0]      req_restore_offset,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [aba_pkg::OFF_W-1:0]      rsp_payload_offset,
   output logic                           rsp_overflow,
   output logic [aba_pkg::OFF_W-1:0]      rsp_current_offset,
   output logic                           rsp_overflow_seen,
   output logic [aba_pkg::CNT_W-1:0]      rsp_alloc_count,
   output logic [aba_pkg::BYTE_W-1:0]     rsp_alloc_bytes,
   output logic [aba_pkg::OFF_W-1:0]      rsp_high_water,
   output logic [aba_pkg::CNT_W-1:0]      rsp_reset_count,
   output logic [aba_pkg::CNT_W-1:0]      rsp_restore_count,
   output logic [aba_pkg::CNT_W-1:0]      rsp_overflow_count,
   output logic [aba_pkg::BYTE_W-1:0]     rsp_spilled_bytes,
   input  logic                           csr_write_en,
   input  logic                           csr_index,
   input  logic [aba_pkg::CSR_W-1:0]      csr_write_data
);

   aba_pkg::req_item_type req_item;
   aba_pkg::req_item_type item;
   logic                  item_valid;
   logic                  advance;
   aba_pkg::rsp_type      result;

   logic                        rsp_valid_ff, rsp_valid_in;
   aba_pkg::rsp_type            rsp_ff;
   logic [aba_pkg::CAP_W-1:0]   capacity_ff;
   logic [aba_pkg::MIS_W-1:0]   misalign_ff;

   assign req_item.kind           = req_kind;
   assign req_item.request_bytes  = req_request_bytes;
   assign req_item.restore_offset = req_restore_offset;

   // The held item moves on whenever the result register is free or draining.
   assign advance = item_valid && (!rsp_valid_ff || !rsp_stall);

   aba_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   aba_engine #(
      .ALIGN_BYTES (ALIGN_BYTES),
      .ADDR_BITS   (ADDR_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .item           (item),
      .arena_capacity (capacity_ff),
      .base_misalign  (misalign_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= aba_pkg::CAPACITY_RESET;
         misalign_ff <= aba_pkg::MISALIGN_RESET;
      end else if (csr_write_en) begin
         case (aba_pkg::csr_index_type'(csr_index))
            aba_pkg::CSR_ARENA_CAPACITY: begin
               capacity_ff <= csr_write_data[aba_pkg::CAP_W-1:0];
            end
            aba_pkg::CSR_BASE_MISALIGN: begin
               misalign_ff <= csr_write_data[aba_pkg::MIS_W-1:0];
            end
            default: begin
               capacity_ff <= capacity_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_offset = rsp_ff.payload_offset;
   assign rsp_overflow       = rsp_ff.overflow;
   assign rsp_current_offset = rsp_ff.current_offset;
   assign rsp_overflow_seen  = rsp_ff.overflow_seen;
   assign rsp_alloc_count    = rsp_ff.alloc_count;
   assign rsp_alloc_bytes    = rsp_ff.alloc_bytes;
   assign rsp_high_water     = rsp_ff.high_water;
   assign rsp_reset_count    = rsp_ff.reset_count;
   assign rsp_restore_count  = rsp_ff.restore_count;
   assign rsp_overflow_count = rsp_ff.overflow_count;
   assign rsp_spilled_bytes  = rsp_ff.spilled_bytes;

   // A failed alloc reports no payload and leaves the sticky flag set.
   `ABA_ASSERT_IMPL(a_ovf_no_payload, clock, reset, rsp_valid && rsp_overflow, rsp_payload_offset == '0 && rsp_overflow_seen)

   // A successful alloc ends below the lifetime high-water mark or on it.
   `ABA_ASSERT_IMPL(a_water_covers, clock, reset, rsp_valid && rsp_payload_offset != '0, rsp_high_water >= rsp_current_offset)

   // A stalled result must hold back the held item.
   `ABA_ASSERT_IMPL(a_stall_blocks, clock, reset, rsp_valid && rsp_stall && item_valid, req_stall)

   // An item that advances always shows up as a valid result next cycle.
   `ABA_ASSERT_NEXT(a_advance_result, clock, reset, advance, rsp_valid)

endmodule

// ===== verif/aligned_bump_arena_allocator_tb.sv =====
// Self-checking testbench for the bump-pointer arena allocator with a built-in command predictor.
`timescale 1ns / 1ps

module aligned_bump_arena_allocator_tb;

   localparam logic [63:0] ALIGN_BYTES = 64'd16;
   localparam logic [aba_pkg::KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
   localparam logic [aba_pkg::KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
   localparam int CHECK_W = aba_pkg::BYTE_W;
   localparam int STUCK_LIMIT = 1000;
   localparam int HOLD_AFTER = 60;
   localparam int HOLD_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [aba_pkg::KIND_W-1:0] req_kind = '0;
   logic [aba_pkg::REQ_W-1:0]  req_request_bytes = '0;
   logic [aba_pkg::REQ_W-1:0]  req_restore_offset = '0;

   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [aba_pkg::OFF_W-1:0]  rsp_payload_offset;
   logic                       rsp_overflow;
   logic [aba_pkg::OFF_W-1:0]  rsp_current_offset;
   logic                       rsp_overflow_seen;
   logic [aba_pkg::CNT_W-1:0]  rsp_alloc_count;
   logic [aba_pkg::BYTE_W-1:0] rsp_alloc_bytes;
   logic [aba_pkg::OFF_W-1:0]  rsp_high_water;
   logic [aba_pkg::CNT_W-1:0]  rsp_reset_count;
   logic [aba_pkg::CNT_W-1:0]  rsp_restore_count;
   logic [aba_pkg::CNT_W-1:0]  rsp_overflow_count;
   logic [aba_pkg::BYTE_W-1:0] rsp_spilled_bytes;

   logic                       csr_write_en = 1'b0;
   logic                       csr_index = 1'b0;
   logic [aba_pkg::CSR_W-1:0]  csr_write_data = '0;

   // Shadow of the arena registers and state.
   logic [aba_pkg::CAP_W-1:0]  cap_cfg;
   logic [aba_pkg::MIS_W-1:0]  mis_cfg;
   logic [aba_pkg::OFF_W-1:0]  arena_off;
   logic                       ovf_flag;
   logic [aba_pkg::CNT_W-1:0]  alloc_events;
   logic [aba_pkg::BYTE_W-1:0] alloc_total;
   logic [aba_pkg::OFF_W-1:0]  water_level;
   logic [aba_pkg::CNT_W-1:0]  reset_events;
   logic [aba_pkg::CNT_W-1:0]  restore_events;
   logic [aba_pkg::CNT_W-1:0]  ovf_events;
   logic [aba_pkg::BYTE_W-1:0] ovf_total;

   aba_pkg::req_item_type pending_cmds[$];
   aba_pkg::rsp_type      expected_results[$];
   aba_pkg::req_item_type offered_cmd;
   aba_pkg::rsp_type      seen_rsp;
   aba_pkg::rsp_type      want_rsp;

   int items_queued = 0;
   int results_done = 0;
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stuck_cycles = 0;

   aligned_bump_arena_allocator i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_request_bytes  (req_request_bytes),
      .req_restore_offset (req_restore_offset),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_overflow       (rsp_overflow),
      .rsp_current_offset (rsp_current_offset),
      .rsp_overflow_seen  (rsp_overflow_seen),
      .rsp_alloc_count    (rsp_alloc_count),
      .rsp_alloc_bytes    (rsp_alloc_bytes),
      .rsp_high_water     (rsp_high_water),
      .rsp_reset_count    (rsp_reset_count),
      .rsp_restore_count  (rsp_restore_count),
      .rsp_overflow_count (rsp_overflow_count),
      .rsp_spilled_bytes  (rsp_spilled_bytes),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #6 clock = ~clock;

   // Padding that moves an offset onto an aligned address relative to the base.
   function automatic logic [63:0] align_pad(logic [63:0] off);
      logic [63:0] rem;
      rem = (64'(mis_cfg) + off) % ALIGN_BYTES;
      return (rem == 64'd0) ? 64'd0 : ALIGN_BYTES - rem;
   endfunction

   function automatic void clear_stats();
      alloc_events = '0;
      alloc_total = '0;
      reset_events = '0;
      restore_events = '0;
      ovf_events = '0;
      ovf_total = '0;
   endfunction

   function automatic aba_pkg::rsp_type predict_result(aba_pkg::req_item_type cmd);
      aba_pkg::rsp_type r;
      logic [63:0]      hdr;
      logic [63:0]      pl;
      logic [63:0]      fin;
      r = '0;
      case (cmd.kind)
         aba_pkg::KIND_ALLOC: begin
            hdr = 64'(arena_off) + 64'(aba_pkg::HDR_BYTES);
            pl = hdr + align_pad(hdr);
            fin = pl + 64'(cmd.request_bytes);
            // The end is compared at full width, so a header past the top still overflows.
            if (fin >= 64'(cap_cfg)) begin
               ovf_events = ovf_events + aba_pkg::CNT_W'(1);
               ovf_total = ovf_total + aba_pkg::BYTE_W'(cmd.request_bytes);
               ovf_flag = 1'b1;
               r.overflow = 1'b1;
            end else begin
               arena_off = fin[aba_pkg::OFF_W-1:0];
               alloc_events = alloc_events + aba_pkg::CNT_W'(1);
               alloc_total = alloc_total + aba_pkg::BYTE_W'(cmd.request_bytes);
               if (fin > 64'(water_level)) begin
                  water_level = fin[aba_pkg::OFF_W-1:0];
               end
               r.payload_offset = pl[aba_pkg::OFF_W-1:0];
            end
         end
         aba_pkg::KIND_ARENA_RESET: begin
            arena_off = '0;
            ovf_flag = 1'b0;
            reset_events = reset_events + aba_pkg::CNT_W'(1);
         end
         aba_pkg::KIND_CKPT_SAVE: begin
         end
         aba_pkg::KIND_CKPT_RESTORE: begin
            arena_off = cmd.restore_offset;
            restore_events = restore_events + aba_pkg::CNT_W'(1);
         end
         aba_pkg::KIND_STATS_CLEAR: begin
            clear_stats();
         end
         aba_pkg::KIND_INIT: begin
            arena_off = aba_pkg::OFF_W'(align_pad(64'd0));
            ovf_flag = 1'b0;
            water_level = '0;
            clear_stats();
         end
         default: begin
         end
      endcase
      r.current_offset = arena_off;
      r.overflow_seen = ovf_flag;
      r.alloc_count = alloc_events;
      r.alloc_bytes = alloc_total;
      r.high_water = water_level;
      r.reset_count = reset_events;
      r.restore_count = restore_events;
      r.overflow_count = ovf_events;
      r.spilled_bytes = ovf_total;
      return r;
   endfunction

   task automatic check_field(string name, logic [CHECK_W-1:0] want, logic [CHECK_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   // Driver: offers pending items and predicts each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_result(offered_cmd));
         end
         if (!req_valid || !req_stall) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered_cmd = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_kind <= offered_cmd.kind;
               req_request_bytes <= offered_cmd.request_bytes;
               req_restore_offset <= offered_cmd.restore_offset;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result and drives the result stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_rsp.payload_offset = rsp_payload_offset;
            seen_rsp.overflow = rsp_overflow;
            seen_rsp.current_offset = rsp_current_offset;
            seen_rsp.overflow_seen = rsp_overflow_seen;
            seen_rsp.alloc_count = rsp_alloc_count;
            seen_rsp.alloc_bytes = rsp_alloc_bytes;
            seen_rsp.high_water = rsp_high_water;
            seen_rsp.reset_count = rsp_reset_count;
            seen_rsp.restore_count = rsp_restore_count;
            seen_rsp.overflow_count = rsp_overflow_count;
            seen_rsp.spilled_bytes = rsp_spilled_bytes;
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: result item with nothing expected, current_offset 0x%0h",
                        $time, rsp_current_offset);
            end else begin
               want_rsp = expected_results.pop_front();
               check_field("payload_offset", CHECK_W'(want_rsp.payload_offset),
                           CHECK_W'(seen_rsp.payload_offset));
               check_field("overflow", CHECK_W'(want_rsp.overflow),
                           CHECK_W'(seen_rsp.overflow));
               check_field("current_offset", CHECK_W'(want_rsp.current_offset),
                           CHECK_W'(seen_rsp.current_offset));
               check_field("overflow_seen", CHECK_W'(want_rsp.overflow_seen),
                           CHECK_W'(seen_rsp.overflow_seen));
               check_field("alloc_count", CHECK_W'(want_rsp.alloc_count),
                           CHECK_W'(seen_rsp.alloc_count));
               check_field("alloc_bytes", want_rsp.alloc_bytes, seen_rsp.alloc_bytes);
               check_field("high_water", CHECK_W'(want_rsp.high_water),
                           CHECK_W'(seen_rsp.high_water));
               check_field("reset_count", CHECK_W'(want_rsp.reset_count),
                           CHECK_W'(seen_rsp.reset_count));
               check_field("restore_count", CHECK_W'(want_rsp.restore_count),
                           CHECK_W'(seen_rsp.restore_count));
               check_field("overflow_count", CHECK_W'(want_rsp.overflow_count),
                           CHECK_W'(seen_rsp.overflow_count));
               check_field("spilled_bytes", want_rsp.spilled_bytes, seen_rsp.spilled_bytes);
            end
            results_done++;
         end
         // One long hold-off lets the block fill up and push back on its input.
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && results_done >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("aligned_bump_arena_allocator_tb: FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic queue_cmd(logic [aba_pkg::KIND_W-1:0] k, logic [aba_pkg::REQ_W-1:0] b,
                            logic [aba_pkg::REQ_W-1:0] o);
      aba_pkg::req_item_type cmd;
      cmd.kind = k;
      cmd.request_bytes = b;
      cmd.restore_offset = o;
      pending_cmds.push_back(cmd);
      items_queued++;
   endtask

   task automatic queue_random(int count);
      int          pick;
      logic [23:0] bytes;
      logic [23:0] rest;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            bytes = 24'($urandom_range(0, 48));
         end else if (pick < 90) begin
            bytes = 24'($urandom_range(0, cap_cfg / 16 + 1));
         end else if (pick < 97) begin
            bytes = 24'($urandom_range(0, cap_cfg));
         end else begin
            bytes = 24'($urandom);
         end
         rest = ($urandom_range(0, 99) < 80) ? 24'($urandom_range(0, cap_cfg)) : 24'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 66) begin
            queue_cmd(aba_pkg::KIND_ALLOC, bytes, rest);
         end else if (pick < 73) begin
            queue_cmd(aba_pkg::KIND_CKPT_SAVE, bytes, rest);
         end else if (pick < 80) begin
            queue_cmd(aba_pkg::KIND_CKPT_RESTORE, bytes, rest);
         end else if (pick < 86) begin
            queue_cmd(aba_pkg::KIND_ARENA_RESET, bytes, rest);
         end else if (pick < 90) begin
            queue_cmd(aba_pkg::KIND_STATS_CLEAR, bytes, rest);
         end else if (pick < 95) begin
            queue_cmd(aba_pkg::KIND_INIT, bytes, rest);
         end else begin
            queue_cmd(pick[0] ? KIND_UNUSED_HI : KIND_UNUSED_LO, bytes, rest);
         end
      end
   endtask

   // Waits until every queued item has returned, then lets the pipeline settle.
   task automatic drain();
      while (results_done < items_queued) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(logic [aba_pkg::CAP_W-1:0] cap, logic [aba_pkg::MIS_W-1:0] mis);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= aba_pkg::CSR_ARENA_CAPACITY;
      csr_write_data <= cap;
      cap_cfg = cap;
      @(posedge clock);
      csr_index <= aba_pkg::CSR_BASE_MISALIGN;
      csr_write_data <= aba_pkg::CSR_W'(mis);
      mis_cfg = mis;
      @(posedge clock);
      csr_write_en <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   initial begin
      cap_cfg = aba_pkg::CAPACITY_RESET;
      mis_cfg = aba_pkg::MISALIGN_RESET;
      arena_off = '0;
      ovf_flag = 1'b0;
      water_level = '0;
      clear_stats();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 38;
      recv_idle_pct = 75;

      // Reset defaults first, then a misaligned base.
      queue_cmd(aba_pkg::KIND_ALLOC, 24'd40, 24'd0);
      drain();
      configure(24'd65536, 4'd5);
      queue_cmd(aba_pkg::KIND_INIT, 24'd0, 24'd0);
      queue_cmd(aba_pkg::KIND_ALLOC, 24'd0, 24'd0);
      queue_cmd(aba_pkg::KIND_ALLOC, 24'd1, 24'd0);
      queue_cmd(aba_pkg::KIND_ALLOC, 24'hFFFFFF, 24'hFFFFFF);
      queue_cmd(aba_pkg::KIND_CKPT_SAVE, 24'd0, 24'd0);
      // Restoring near the top makes the header cross the 24-bit boundary.
      queue_cmd(aba_pkg::KIND_CKPT_RESTORE, 24'd0, 24'hFFFFF8);
      queue_cmd(aba_pkg::KIND_ALLOC, 24'd0, 24'd0);
      queue_cmd(aba_pkg::KIND_ARENA_RESET, 24'd0, 24'd0);
      queue_cmd(aba_pkg::KIND_ALLOC, 24'd65525, 24'd0);
      queue_cmd(aba_pkg::KIND_ALLOC, 24'd65524, 24'd0);
      queue_cmd(aba_pkg::KIND_STATS_CLEAR, 24'd0, 24'd0);
      queue_cmd(KIND_UNUSED_LO, 24'h123456, 24'h654321);
      queue_cmd(KIND_UNUSED_HI, 24'hFFFFFF, 24'hFFFFFF);
      queue_cmd(aba_pkg::KIND_CKPT_RESTORE, 24'hAAAAAA, 24'h555555);
      queue_cmd(aba_pkg::KIND_CKPT_RESTORE, 24'h555555, 24'hAAAAAA);
      queue_cmd(aba_pkg::KIND_CKPT_RESTORE, 24'd0, 24'd0);
      queue_cmd(aba_pkg::KIND_ALLOC, 24'd16, 24'd0);
      queue_cmd(aba_pkg::KIND_CKPT_SAVE, 24'd0, 24'd0);
      queue_cmd(aba_pkg::KIND_INIT, 24'd0, 24'd0);
      queue_random(90);
      drain();

      // With no capacity every alloc must overflow.
      configure(24'd0, 4'd15);
      queue_cmd(aba_pkg::KIND_INIT, 24'd0, 24'd0);
      queue_cmd(aba_pkg::KIND_ALLOC, 24'd0, 24'd0);
      queue_cmd(aba_pkg::KIND_ALLOC, 24'd5, 24'd0);
      queue_random(30);
      drain();

      send_idle_pct = 75;
      recv_idle_pct = 38;
      configure(24'hFFFFFF, 4'd0);
      queue_cmd(aba_pkg::KIND_INIT, 24'd0, 24'd0);
      queue_random(90);
      drain();

      configure(24'd600, 4'd9);
      queue_cmd(aba_pkg::KIND_INIT, 24'd0, 24'd0);
      queue_random(100);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(24'($urandom_range(200, 70000)), 4'($urandom));
      queue_cmd(aba_pkg::KIND_INIT, 24'd0, 24'd0);
      queue_random(100);
      drain();

      configure(24'd1, 4'd1);
      queue_random(40);
      drain();

      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         errors++;
         $display("%0t: %0d expected result items never arrived", $time,
                  expected_results.size());
      end
      if (errors == 0) begin
         $display("aligned_bump_arena_allocator_tb: PASS");
      end else begin
         $display("aligned_bump_arena_allocator_tb: FAIL");
      end
      $finish;
   end

endmodule
